@@ hdl/tssc_pkg.sv @@
// Shared types and constants for the throttle safety slew controller.
// Used by every module of the block and by its port checker.
package tssc_pkg;

  typedef enum logic [3:0] {
    FN_TICK       = 4'd0,
    FN_ZERO       = 4'd1,
    FN_DISARM     = 4'd2,
    FN_CLEARFAULT = 4'd3,
    FN_ARM        = 4'd4,
    FN_SET_LIMIT  = 4'd5,
    FN_DRIVE      = 4'd6,
    FN_RELAY      = 4'd7,
    FN_STATUS     = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_BAD_ARG     = 3'd1,
    RC_REJECTED    = 3'd2,
    RC_LINK_REJECT = 3'd3,
    RC_FORCED_STOP = 3'd4,
    RC_WATCHDOG    = 3'd5,
    RC_BUSY        = 3'd6,
    RC_RELAY_DONE  = 3'd7
  } code_e;

  typedef enum logic [2:0] {
    CFG_RAMP_STEP      = 3'd0,
    CFG_RAMP_INTERVAL  = 3'd1,
    CFG_CMD_TIMEOUT    = 3'd2,
    CFG_ZERO_TIMEOUT   = 3'd3,
    CFG_APPROVED_LIMIT = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_BOTH  = 2'd2;
  localparam logic [1:0] SIDE_BAD   = 2'd3;

  localparam logic [6:0]  RstRampStep      = 7'd5;
  localparam logic [7:0]  RstRampInterval  = 8'd10;
  localparam logic [15:0] RstCmdTimeout    = 16'd2000;
  localparam logic [15:0] RstZeroTimeout   = 16'd1500;
  localparam logic [7:0]  RstApprovedLimit = 8'd193;
  localparam logic [7:0]  RstThrottleLimit = 8'd96;

  typedef struct packed {
    logic [6:0]  slew_step;
    logic [7:0]  ramp_interval;
    logic [15:0] cmd_timeout;
    logic [15:0] zero_timeout;
    logic [7:0]  approved_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] left_value;
    logic [7:0] right_value;
    logic [1:0] relay_side;
    logic       left_link_ok;
    logic       right_link_ok;
  } item_t;

  typedef struct packed {
    logic        armed;
    logic        fault;
    logic [7:0]  level_l;
    logic [7:0]  level_r;
    logic [7:0]  goal_l;
    logic [7:0]  goal_r;
    logic        rev_l;
    logic        rev_r;
    logic [7:0]  limit;
    logic [15:0] since_cmd;
    logic [7:0]  since_ramp;
    logic        zero_pend;
    logic [1:0]  pend_side;
    logic        pend_rev;
    logic [15:0] zero_elapsed;
  } state_t;

  typedef struct packed {
    code_e      result_code;
    logic       armed;
    logic       faulted;
    logic [7:0] left_level;
    logic [7:0] right_level;
    logic [7:0] left_goal;
    logic [7:0] right_goal;
    logic       left_reverse;
    logic       right_reverse;
    logic       zeroing_busy;
    logic       left_write;
    logic       right_write;
  } result_t;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

endpackage

@@ hdl/tssc_cfg.sv @@
// Configuration register file of the throttle safety slew controller.
// Depends on tssc_pkg for the register layout and reset values.
module tssc_cfg
  import tssc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_RAMP_STEP:      cfg_d.slew_step      = data_i[6:0];
        CFG_RAMP_INTERVAL:  cfg_d.ramp_interval  = data_i[7:0];
        CFG_CMD_TIMEOUT:    cfg_d.cmd_timeout    = data_i;
        CFG_ZERO_TIMEOUT:   cfg_d.zero_timeout   = data_i;
        CFG_APPROVED_LIMIT: cfg_d.approved_limit = data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slew_step      <= RstRampStep;
      cfg_q.ramp_interval  <= RstRampInterval;
      cfg_q.cmd_timeout    <= RstCmdTimeout;
      cfg_q.zero_timeout   <= RstZeroTimeout;
      cfg_q.approved_limit <= RstApprovedLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/tssc_step.sv @@
// Next-state and result logic for one tick or command of the controller.
// Purely combinational; depends on tssc_pkg for state, item and result types.
module tssc_step
  import tssc_pkg::*;
(
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output state_t  st_o,
  output result_t res_o
);

  // One slew step from cur toward goal, never overshooting.
  function automatic logic [7:0] ramp_next(logic [7:0] cur, logic [7:0] goal, logic [6:0] step);
    logic [8:0] sum;
    logic [7:0] diff;
    logic [7:0] nxt;
    sum  = {1'b0, cur} + {2'b00, step};
    diff = cur - goal;
    if (cur < goal) begin
      nxt = (sum > {1'b0, goal}) ? goal : sum[7:0];
    end else begin
      nxt = (diff < {1'b0, step}) ? goal : cur - {1'b0, step};
    end
    return nxt;
  endfunction

  // Zero writes reach only the converters whose link is up.
  function automatic state_t drop_outputs(state_t s, logic ll, logic lr);
    state_t r;
    r        = s;
    r.armed  = 1'b0;
    r.goal_l = '0;
    r.goal_r = '0;
    r.rev_l  = 1'b0;
    r.rev_r  = 1'b0;
    if (ll) r.level_l = '0;
    if (lr) r.level_r = '0;
    return r;
  endfunction

  function automatic state_t apply_relays(state_t s);
    state_t r;
    r = s;
    if (s.pend_side == SIDE_LEFT || s.pend_side == SIDE_BOTH) r.rev_l = s.pend_rev;
    if (s.pend_side == SIDE_RIGHT || s.pend_side == SIDE_BOTH) r.rev_r = s.pend_rev;
    r.zero_pend = 1'b0;
    return r;
  endfunction

  state_t     n;
  code_e      code;
  logic       sl;
  logic       sr;
  logic       ll;
  logic       lr;
  logic       rt_fail;
  logic [7:0] lv;
  logic [7:0] rv;

  always_comb begin
    n       = st_i;
    code    = RC_OK;
    sl      = 1'b0;
    sr      = 1'b0;
    rt_fail = 1'b0;
    ll      = item_i.left_link_ok;
    lr      = item_i.right_link_ok;
    lv      = item_i.left_value;
    rv      = item_i.right_value;

    if (func_e'(item_i.func) == FN_TICK) begin
      if (n.since_cmd != 16'hFFFF) n.since_cmd = n.since_cmd + 16'd1;
      if (n.zero_pend && n.zero_elapsed != 16'hFFFF) begin
        n.zero_elapsed = n.zero_elapsed + 16'd1;
      end

      // Slew both wheels once per interval; a left failure skips the right write.
      if (n.since_ramp != 8'hFF) n.since_ramp = n.since_ramp + 8'd1;
      if (n.since_ramp >= cfg_i.ramp_interval) begin
        n.since_ramp = '0;
        if (n.level_l != n.goal_l) begin
          sl = 1'b1;
          if (ll) n.level_l = ramp_next(n.level_l, n.goal_l, cfg_i.slew_step);
          else    rt_fail   = 1'b1;
        end
        if (!rt_fail && n.level_r != n.goal_r) begin
          sr = 1'b1;
          if (lr) n.level_r = ramp_next(n.level_r, n.goal_r, cfg_i.slew_step);
          else    rt_fail   = 1'b1;
        end
        if (rt_fail) begin
          n       = drop_outputs(n, ll, lr);
          n.fault = 1'b1;
          sl      = 1'b1;
          sr      = 1'b1;
        end
      end

      if (st_i.zero_pend) begin
        if (n.fault || n.zero_elapsed > cfg_i.zero_timeout) begin
          n           = drop_outputs(n, ll, lr);
          n.fault     = 1'b1;
          n.zero_pend = 1'b0;
          sl          = 1'b1;
          sr          = 1'b1;
          code        = RC_FORCED_STOP;
        end else if (n.level_l == '0 && n.level_r == '0) begin
          n    = apply_relays(n);
          code = RC_RELAY_DONE;
        end
      end else if (rt_fail) begin
        code = RC_FORCED_STOP;
      end else if (n.armed && n.since_cmd > cfg_i.cmd_timeout) begin
        n = drop_outputs(n, ll, lr);
        if (!ll || !lr) n.fault = 1'b1;
        sl   = 1'b1;
        sr   = 1'b1;
        code = RC_WATCHDOG;
      end
    end else if (n.zero_pend) begin
      code = RC_BUSY;
    end else begin
      unique case (func_e'(item_i.func))
        FN_ZERO: begin
          n.goal_l    = '0;
          n.goal_r    = '0;
          n.since_cmd = '0;
        end
        FN_DISARM: begin
          n  = drop_outputs(n, ll, lr);
          sl = 1'b1;
          sr = 1'b1;
          if (!ll || !lr) begin
            n.fault = 1'b1;
            code    = RC_FORCED_STOP;
          end
        end
        FN_CLEARFAULT: begin
          if (n.armed || n.level_l != '0 || n.level_r != '0 || n.rev_l || n.rev_r) begin
            code = RC_REJECTED;
          end else if (!ll || !lr) begin
            code = RC_LINK_REJECT;
          end else begin
            sl      = 1'b1;
            sr      = 1'b1;
            n.fault = 1'b0;
          end
        end
        FN_ARM: begin
          if (n.fault) begin
            code = RC_REJECTED;
          end else if (!ll || !lr) begin
            n       = drop_outputs(n, ll, lr);
            n.fault = 1'b1;
            sl      = 1'b1;
            sr      = 1'b1;
            code    = RC_FORCED_STOP;
          end else begin
            sl          = 1'b1;
            sr          = 1'b1;
            n.level_l   = '0;
            n.level_r   = '0;
            n.goal_l    = '0;
            n.goal_r    = '0;
            n.armed     = 1'b1;
            n.since_cmd = '0;
          end
        end
        FN_SET_LIMIT: begin
          if (lv > cfg_i.approved_limit) begin
            code = RC_BAD_ARG;
          end else begin
            n.limit = lv;
            if (n.goal_l > lv) n.goal_l = lv;
            if (n.goal_r > lv) n.goal_r = lv;
          end
        end
        FN_DRIVE: begin
          if (lv > cfg_i.approved_limit || rv > cfg_i.approved_limit) begin
            code = RC_BAD_ARG;
          end else if (!n.armed && (lv != '0 || rv != '0)) begin
            code = RC_REJECTED;
          end else begin
            n.goal_l    = (lv < n.limit) ? lv : n.limit;
            n.goal_r    = (rv < n.limit) ? rv : n.limit;
            n.since_cmd = '0;
          end
        end
        FN_RELAY: begin
          if (item_i.relay_side == SIDE_BAD || lv > 8'd1) begin
            code = RC_BAD_ARG;
          end else if (lv[0] && n.fault) begin
            code = RC_REJECTED;
          end else begin
            n.armed     = 1'b0;
            n.goal_l    = '0;
            n.goal_r    = '0;
            n.pend_side = item_i.relay_side;
            n.pend_rev  = lv[0];
            if (n.level_l == '0 && n.level_r == '0) begin
              n    = apply_relays(n);
              code = RC_RELAY_DONE;
            end else if (n.fault) begin
              n    = drop_outputs(n, ll, lr);
              sl   = 1'b1;
              sr   = 1'b1;
              code = RC_FORCED_STOP;
            end else begin
              n.zero_pend    = 1'b1;
              n.zero_elapsed = '0;
            end
          end
        end
        FN_STATUS: ;
        default: code = RC_BAD_ARG;
      endcase
    end
  end

  assign st_o = n;

  always_comb begin
    res_o.result_code   = code;
    res_o.armed         = n.armed;
    res_o.faulted       = n.fault;
    res_o.left_level    = n.level_l;
    res_o.right_level   = n.level_r;
    res_o.left_goal     = n.goal_l;
    res_o.right_goal    = n.goal_r;
    res_o.left_reverse  = n.rev_l;
    res_o.right_reverse = n.rev_r;
    res_o.zeroing_busy  = n.zero_pend;
    res_o.left_write    = sl;
    res_o.right_write   = sr;
  end

endmodule

@@ hdl/throttle_safety_slew_controller_unit.sv @@
// Throttle safety slew controller, top level.
// Each item is held in the input register and its result in the result register.
// Throughput: one item per cycle; the input register refills while its item moves
// on, which it does whenever the result register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears all flags, levels, counters and the
// configuration to its defaults; both streams come up empty.
module throttle_safety_slew_controller_unit
  import tssc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func[3:0], left_value[11:4], right_value[19:12], relay_side[21:20],
  // left_link_ok[22], right_link_ok[23]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_code[2:0], armed[3], faulted[4], left_level[12:5], right_level[20:13],
  // left_goal[28:21], right_goal[36:29], left_reverse[37], right_reverse[38],
  // zeroing_busy[39], left_write[40], right_write[41], zero fill[47:42]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  logic    in_vld_d;
  state_t  st_q;
  state_t  st_next;
  result_t res_next;
  result_t res_q;
  logic    res_vld_q;
  logic    res_vld_d;
  logic    adv;
  logic    in_xfer;
  logic    proc;

  tssc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tssc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .item_i (item_q),
    .st_o   (st_next),
    .res_o  (res_next)
  );

  assign adv           = !res_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign proc          = in_vld_q && adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer)  in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    res_vld_d = res_vld_q;
    if (proc)               res_vld_d = 1'b1;
    else if (m_axis_tready) res_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.func          <= s_axis_tdata[3:0];
      item_q.left_value    <= s_axis_tdata[11:4];
      item_q.right_value   <= s_axis_tdata[19:12];
      item_q.relay_side    <= s_axis_tdata[21:20];
      item_q.left_link_ok  <= s_axis_tdata[22];
      item_q.right_link_ok <= s_axis_tdata[23];
    end
    if (proc) res_q <= res_next;
  end

  // Controller state advances once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{limit: RstThrottleLimit, default: '0};
    end else if (proc) begin
      st_q <= st_next;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {6'b000000,
                          res_q.right_write,
                          res_q.left_write,
                          res_q.zeroing_busy,
                          res_q.right_reverse,
                          res_q.left_reverse,
                          res_q.right_goal,
                          res_q.left_goal,
                          res_q.right_level,
                          res_q.left_level,
                          res_q.faulted,
                          res_q.armed,
                          res_q.result_code};

endmodule

@@ hdl/tssc_checker.sv @@
// Port-level checker for the throttle safety slew controller, bound to the top.
// Depends on tssc_pkg for the result codes.
module tssc_checker
  import tssc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic       o_armed;
  logic       o_fault;
  logic       o_busy;
  logic [2:0] o_code;
  logic [7:0] o_lvl_l;
  logic [7:0] o_lvl_r;

  assign o_code  = m_axis_tdata[2:0];
  assign o_armed = m_axis_tdata[3];
  assign o_fault = m_axis_tdata[4];
  assign o_lvl_l = m_axis_tdata[12:5];
  assign o_lvl_r = m_axis_tdata[20:13];
  assign o_busy  = m_axis_tdata[39];

  // A result that is not taken must stay put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Arming needs a clear fault, and every fault path disarms.
  a_fault_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_fault |-> !o_armed)
    else $error("armed while faulted");

  // A pending relay change always starts from a disarmed block.
  a_zero_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_busy |-> !o_armed)
    else $error("armed while zeroing");

  // Relays only switch with both wheels at zero.
  a_relay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_code == RC_RELAY_DONE |->
      o_lvl_l == 8'd0 && o_lvl_r == 8'd0 && !o_busy)
    else $error("relay applied with nonzero level");

endmodule

bind throttle_safety_slew_controller_unit tssc_checker u_tssc_checker (.*);

@@ tb/tb_throttle_safety_slew_controller_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for throttle_safety_slew_controller_unit: a directed table followed by
// random command sequences, checked against a behavioral predictor. Depends on tssc_pkg only.
module tb_throttle_safety_slew_controller_unit;
  import tssc_pkg::*;

  localparam logic [3:0] FnUnknown   = 4'hF;
  localparam logic [7:0] RelayFwd    = 8'd0;
  localparam logic [7:0] RelayRev    = 8'd1;
  localparam int         NumDir      = 27;
  localparam int         NumPhases   = 10;
  localparam int         PhaseItems  = 100;
  localparam int         HoldAfter   = 300;
  localparam int         HoldCycles  = 150;
  localparam int         IdleLimit   = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  throttle_safety_slew_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Controller state as the predictor sees it; index 0 is the left wheel.
  int unsigned cfg_step, cfg_intv, cfg_cmd_to, cfg_zero_to, cfg_appr;
  logic        arm_st, flt_st;
  logic [7:0]  lvl [2];
  logic [7:0]  goal [2];
  logic        rev [2];
  logic [7:0]  lim;
  logic [15:0] cmd_age;
  logic [7:0]  ramp_age;
  logic        zpend;
  logic [1:0]  zside;
  logic        zrev;
  logic [15:0] zage;
  logic        lnk [2];
  logic        wr [2];

  result_t expected_status_q [$];
  int      fail_count   = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      tx_calm      = 0;

  typedef struct {
    logic [3:0] fn;
    logic [7:0] lv;
    logic [7:0] rv;
    logic [1:0] sd;
    logic       ll;
    logic       rl;
    bit         typed;
    code_e      rc;
  } dir_row_t;

  // Runs with ramp_interval 1 so every tick ramps.
  dir_row_t dir_tbl [NumDir] = '{
    '{FN_STATUS,     8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FnUnknown,     8'd255,   8'd255, SIDE_BAD,   1'b1, 1'b1, 1'b1, RC_BAD_ARG},
    '{FN_DRIVE,      8'd10,    8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_REJECTED},
    '{FN_DRIVE,      8'd255,   8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_BAD_ARG},
    '{FN_SET_LIMIT,  8'd194,   8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_BAD_ARG},
    '{FN_SET_LIMIT,  8'd193,   8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_CLEARFAULT, 8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_ARM,        8'd0,     8'd0,   SIDE_LEFT,  1'b0, 1'b1, 1'b1, RC_FORCED_STOP},
    '{FN_ARM,        8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_REJECTED},
    '{FN_RELAY,      RelayRev, 8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_REJECTED},
    '{FN_CLEARFAULT, 8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b0, 1'b1, RC_LINK_REJECT},
    '{FN_CLEARFAULT, 8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_ARM,        8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_DRIVE,      8'd193,   8'd40,  SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_TICK,       8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b0, RC_OK},
    '{FN_RELAY,      RelayFwd, 8'd0,   SIDE_BAD,   1'b1, 1'b1, 1'b1, RC_BAD_ARG},
    '{FN_RELAY,      8'd2,     8'd0,   SIDE_BOTH,  1'b1, 1'b1, 1'b1, RC_BAD_ARG},
    '{FN_RELAY,      RelayRev, 8'd0,   SIDE_BOTH,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_STATUS,     8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_BUSY},
    '{FN_TICK,       8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_RELAY_DONE},
    '{FN_ARM,        8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_DRIVE,      8'd50,    8'd50,  SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_TICK,       8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b0, RC_OK},
    '{FN_ZERO,       8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b1, 1'b1, RC_OK},
    '{FN_DISARM,     8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b0, 1'b1, RC_FORCED_STOP},
    '{FN_RELAY,      RelayFwd, 8'd0,   SIDE_RIGHT, 1'b1, 1'b0, 1'b1, RC_FORCED_STOP},
    '{FN_TICK,       8'd0,     8'd0,   SIDE_LEFT,  1'b1, 1'b0, 1'b1, RC_FORCED_STOP}
  };

  function automatic void reset_predictor();
    cfg_step    = RstRampStep;
    cfg_intv    = RstRampInterval;
    cfg_cmd_to  = RstCmdTimeout;
    cfg_zero_to = RstZeroTimeout;
    cfg_appr    = RstApprovedLimit;
    arm_st   = 1'b0;
    flt_st   = 1'b0;
    lvl      = '{8'd0, 8'd0};
    goal     = '{8'd0, 8'd0};
    rev      = '{1'b0, 1'b0};
    lim      = RstThrottleLimit;
    cmd_age  = '0;
    ramp_age = '0;
    zpend    = 1'b0;
    zside    = SIDE_LEFT;
    zrev     = 1'b0;
    zage     = '0;
  endfunction

  function automatic bit write_level(int w, int v);
    wr[w] = 1'b1;
    if (!lnk[w]) return 1'b0;
    lvl[w] = 8'(v);
    return 1'b1;
  endfunction

  function automatic void trip();
    arm_st  = 1'b0;
    flt_st  = 1'b1;
    goal[0] = '0;
    goal[1] = '0;
    rev[0]  = 1'b0;
    rev[1]  = 1'b0;
    void'(write_level(0, 0));
    void'(write_level(1, 0));
  endfunction

  function automatic bit shut_down();
    bit okl, okr;
    arm_st  = 1'b0;
    goal[0] = '0;
    goal[1] = '0;
    okl = write_level(0, 0);
    okr = write_level(1, 0);
    rev[0] = 1'b0;
    rev[1] = 1'b0;
    if (!okl || !okr) begin
      flt_st = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit slew_wheel(int w);
    int cur, tgt, nxt;
    cur = lvl[w];
    tgt = goal[w];
    if (cur == tgt) return 1'b1;
    if (cur < tgt) begin
      nxt = cur + int'(cfg_step);
      if (nxt > tgt) nxt = tgt;
    end else begin
      nxt = (cur - tgt < int'(cfg_step)) ? tgt : cur - int'(cfg_step);
    end
    return write_level(w, nxt);
  endfunction

  // Returns 1 when a failed ramp write forced a stop. The right wheel is not
  // tried once the left one has failed.
  function automatic bit slew_tick();
    bit ok;
    if (ramp_age != 8'hFF) ramp_age++;
    if (ramp_age < cfg_intv) return 1'b0;
    ramp_age = '0;
    ok = slew_wheel(0);
    if (ok) ok = slew_wheel(1);
    if (!ok) begin
      trip();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void set_relays();
    if (zside == SIDE_LEFT || zside == SIDE_BOTH) rev[0] = zrev;
    if (zside == SIDE_RIGHT || zside == SIDE_BOTH) rev[1] = zrev;
    zpend = 1'b0;
  endfunction

  function automatic code_e tick_step();
    if (cmd_age != 16'hFFFF) cmd_age++;
    if (zpend) begin
      if (zage != 16'hFFFF) zage++;
      void'(slew_tick());
      if (flt_st || zage > cfg_zero_to) begin
        trip();
        zpend = 1'b0;
        return RC_FORCED_STOP;
      end
      if (lvl[0] == 0 && lvl[1] == 0) begin
        set_relays();
        return RC_RELAY_DONE;
      end
      return RC_OK;
    end
    if (slew_tick()) return RC_FORCED_STOP;
    if (arm_st && cmd_age > cfg_cmd_to) begin
      void'(shut_down());
      return RC_WATCHDOG;
    end
    return RC_OK;
  endfunction

  function automatic code_e relay_cmd(logic [1:0] sd, logic [7:0] val);
    if (sd == SIDE_BAD || val > RelayRev) return RC_BAD_ARG;
    if (val == RelayRev && flt_st) return RC_REJECTED;
    arm_st  = 1'b0;
    goal[0] = '0;
    goal[1] = '0;
    zside   = sd;
    zrev    = val[0];
    if (lvl[0] == 0 && lvl[1] == 0) begin
      set_relays();
      return RC_RELAY_DONE;
    end
    if (flt_st) begin
      trip();
      return RC_FORCED_STOP;
    end
    zpend = 1'b1;
    zage  = '0;
    return RC_OK;
  endfunction

  function automatic result_t controller_step(item_t it);
    code_e   rc;
    result_t r;
    lnk[0] = it.left_link_ok;
    lnk[1] = it.right_link_ok;
    wr[0]  = 1'b0;
    wr[1]  = 1'b0;
    rc     = RC_OK;
    if (it.func == FN_TICK) begin
      rc = tick_step();
    end else if (zpend) begin
      rc = RC_BUSY;
    end else begin
      case (it.func)
        FN_ZERO: begin
          goal[0] = '0;
          goal[1] = '0;
          cmd_age = '0;
        end
        FN_DISARM: rc = shut_down() ? RC_OK : RC_FORCED_STOP;
        FN_CLEARFAULT: begin
          if (arm_st || lvl[0] != 0 || lvl[1] != 0 || rev[0] || rev[1]) begin
            rc = RC_REJECTED;
          end else if (!lnk[0] || !lnk[1]) begin
            rc = RC_LINK_REJECT;
          end else begin
            void'(write_level(0, 0));
            void'(write_level(1, 0));
            flt_st = 1'b0;
          end
        end
        FN_ARM: begin
          if (flt_st) begin
            rc = RC_REJECTED;
          end else if (!lnk[0] || !lnk[1]) begin
            trip();
            rc = RC_FORCED_STOP;
          end else begin
            void'(write_level(0, 0));
            void'(write_level(1, 0));
            goal[0] = '0;
            goal[1] = '0;
            arm_st  = 1'b1;
            cmd_age = '0;
          end
        end
        FN_SET_LIMIT: begin
          if (it.left_value > cfg_appr) begin
            rc = RC_BAD_ARG;
          end else begin
            lim = it.left_value;
            if (goal[0] > lim) goal[0] = lim;
            if (goal[1] > lim) goal[1] = lim;
          end
        end
        FN_DRIVE: begin
          if (it.left_value > cfg_appr || it.right_value > cfg_appr) begin
            rc = RC_BAD_ARG;
          end else if (!arm_st && (it.left_value != 0 || it.right_value != 0)) begin
            rc = RC_REJECTED;
          end else begin
            goal[0] = (it.left_value < lim) ? it.left_value : lim;
            goal[1] = (it.right_value < lim) ? it.right_value : lim;
            cmd_age = '0;
          end
        end
        FN_RELAY:  rc = relay_cmd(it.relay_side, it.left_value);
        FN_STATUS: rc = RC_OK;
        default:   rc = RC_BAD_ARG;
      endcase
    end
    r.result_code   = rc;
    r.armed         = arm_st;
    r.faulted       = flt_st;
    r.left_level    = lvl[0];
    r.right_level   = lvl[1];
    r.left_goal     = goal[0];
    r.right_goal    = goal[1];
    r.left_reverse  = rev[0];
    r.right_reverse = rev[1];
    r.zeroing_busy  = zpend;
    r.left_write    = wr[0];
    r.right_write   = wr[1];
    return r;
  endfunction

  function automatic item_t mk_item(logic [3:0] f, logic [7:0] lv, logic [7:0] rv,
                                    logic [1:0] sd, logic ll, logic rl);
    item_t it;
    it.func          = f;
    it.left_value    = lv;
    it.right_value   = rv;
    it.relay_side    = sd;
    it.left_link_ok  = ll;
    it.right_link_ok = rl;
    return it;
  endfunction

  function automatic logic [InDataW-1:0] pack_item(item_t it);
    return {it.right_link_ok, it.left_link_ok, it.relay_side, it.right_value,
            it.left_value, it.func};
  endfunction

  function automatic result_t decode_status(logic [OutDataW-1:0] d);
    result_t r;
    r.result_code   = code_e'(d[2:0]);
    r.armed         = d[3];
    r.faulted       = d[4];
    r.left_level    = d[12:5];
    r.right_level   = d[20:13];
    r.left_goal     = d[28:21];
    r.right_goal    = d[36:29];
    r.left_reverse  = d[37];
    r.right_reverse = d[38];
    r.zeroing_busy  = d[39];
    r.left_write    = d[40];
    r.right_write   = d[41];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one; now and
  // then a run of items with no gaps at all.
  function automatic int sender_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) tx_calm = $urandom_range(20, 60);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic link_bit();
    return ($urandom_range(0, 99) >= 3);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with tvalid still high, so the caller must drive the next item or drop it.
  task automatic send_item(item_t it, bit typed = 1'b0, code_e rc = RC_OK);
    int      gap;
    result_t r;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = InDataW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pack_item(it);
    do @(posedge clk_i); while (!s_axis_tready);
    r = controller_step(it);
    if (typed) r.result_code = rc;
    expected_status_q.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CfgDataW'(val);
    case (idx)
      CFG_RAMP_STEP:      cfg_step    = val & 32'h7F;
      CFG_RAMP_INTERVAL:  cfg_intv    = val & 32'hFF;
      CFG_CMD_TIMEOUT:    cfg_cmd_to  = val & 32'hFFFF;
      CFG_ZERO_TIMEOUT:   cfg_zero_to = val & 32'hFFFF;
      CFG_APPROVED_LIMIT: cfg_appr    = val & 32'hFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Registers change only with the pipeline drained.
  task automatic configure(int unsigned step, int unsigned intv, int unsigned cto,
                           int unsigned zto, int unsigned appr);
    s_axis_tvalid = 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(CFG_RAMP_STEP, step);
    write_reg(CFG_RAMP_INTERVAL, intv);
    write_reg(CFG_CMD_TIMEOUT, cto);
    write_reg(CFG_ZERO_TIMEOUT, zto);
    write_reg(CFG_APPROVED_LIMIT, appr);
  endtask

  task automatic send_tick();
    send_item(mk_item(FN_TICK, 8'($urandom), 8'($urandom), 2'($urandom),
                      link_bit(), link_bit()));
  endtask

  // Most traffic is a bring-up (clear, arm, drive, ticks) or a relay change
  // followed by ticks; the rest is set-limit and fully random noise.
  task automatic run_random(int n);
    int stop_at, pick, k;
    logic [7:0] lv, rv;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(mk_item(FN_CLEARFAULT, 8'($urandom), 8'($urandom), 2'($urandom),
                          1'b1, 1'b1));
        send_item(mk_item(FN_ARM, 8'($urandom), 8'($urandom), 2'($urandom), 1'b1, 1'b1));
        k = $urandom_range(1, 25);
        for (int i = 0; i <= k; i++) begin
          if (i == 0 || $urandom_range(0, 9) == 0) begin
            lv = 8'($urandom_range(0, cfg_appr));
            rv = 8'($urandom_range(0, cfg_appr));
            if ($urandom_range(0, 9) == 0) lv = 8'($urandom);
            send_item(mk_item(FN_DRIVE, lv, rv, 2'($urandom), link_bit(), link_bit()));
          end else begin
            send_tick();
          end
        end
      end else if (pick < 75) begin
        send_item(mk_item(FN_RELAY, 8'($urandom_range(0, 1)), 8'($urandom),
                          2'($urandom_range(0, 2)), link_bit(), link_bit()));
        k = $urandom_range(1, 25);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(mk_item(FN_STATUS, 8'($urandom), 8'($urandom), 2'($urandom),
                              link_bit(), link_bit()));
          else
            send_tick();
        end
      end else if (pick < 82) begin
        send_item(mk_item(FN_SET_LIMIT, 8'($urandom), 8'($urandom), 2'($urandom),
                          link_bit(), link_bit()));
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_item(mk_item(4'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                            1'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_RAMP_STEP;
    cfg_data_i    = '0;
    reset_predictor();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    configure(RstRampStep, 1, RstCmdTimeout, RstZeroTimeout, RstApprovedLimit);
    foreach (dir_tbl[i])
      send_item(mk_item(dir_tbl[i].fn, dir_tbl[i].lv, dir_tbl[i].rv, dir_tbl[i].sd,
                        dir_tbl[i].ll, dir_tbl[i].rl), dir_tbl[i].typed, dir_tbl[i].rc);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: configure(64, 1, 65535, 65535, 255);
        1: configure(1, 255, 1, 1, 0);
        2: configure(0, 0, 0, 0, 193);
        3: configure(127, 2, 20, 10, 255);
        NumPhases - 1: configure(RstRampStep, RstRampInterval, RstCmdTimeout,
                                 RstZeroTimeout, RstApprovedLimit);
        default: configure($urandom_range(1, 64), $urandom_range(1, 5),
                           $urandom_range(3, 50), $urandom_range(2, 30),
                           $urandom_range(0, 255));
      endcase
      run_random(PhaseItems);
    end

    s_axis_tvalid = 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** throttle_safety_slew_controller_unit: PASSED **");
    end else begin
      $display("** throttle_safety_slew_controller_unit: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off so the
  // block fills up and pushes back on its input.
  initial begin : result_sink
    int stall, calm, r;
    bit held;
    stall = 0;
    calm  = 0;
    held  = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if (calm > 0) begin
          calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 20)      stall = $urandom_range(1, 3);
          else if (r < 23) stall = $urandom_range(8, 30);
          else if (r < 24) calm  = $urandom_range(30, 100);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = decode_status(m_axis_tdata);
      if (expected_status_q.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("result_code", want.result_code, got.result_code);
        check_field("armed", want.armed, got.armed);
        check_field("faulted", want.faulted, got.faulted);
        check_field("left_level", want.left_level, got.left_level);
        check_field("right_level", want.right_level, got.right_level);
        check_field("left_goal", want.left_goal, got.left_goal);
        check_field("right_goal", want.right_goal, got.right_goal);
        check_field("left_reverse", want.left_reverse, got.left_reverse);
        check_field("right_reverse", want.right_reverse, got.right_reverse);
        check_field("zeroing_busy", want.zeroing_busy, got.zeroing_busy);
        check_field("left_write", want.left_write, got.left_write);
        check_field("right_write", want.right_write, got.right_write);
      end
    end
  end

  // A correct run never goes this long without a transfer or a register write.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** throttle_safety_slew_controller_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
hdl/tssc_pkg.sv
hdl/tssc_cfg.sv
hdl/tssc_step.sv
hdl/throttle_safety_slew_controller_unit.sv
hdl/tssc_checker.sv
tb/tb_throttle_safety_slew_controller_unit.sv
